[rtl/dpat_pkg.sv]
// ----------------------------------------------------------------------------
// dpat_pkg: shared constants of the page translator
// Command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dpat_pkg;

    localparam int unsigned NUM_PAGES_DEF = 1024;

    // command codes
    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;
    localparam logic [1:0] CMD_INVERSE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NEW    = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;
    localparam logic [1:0] ST_MAPPED = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PHYS_BASE  = 2'd0;
    localparam logic [1:0] REG_PAGE_SHIFT = 2'd1;
    localparam logic [1:0] REG_PAGE_COUNT = 2'd2;

    localparam logic [5:0]  SHIFT_RESET = 6'd12;
    localparam logic [10:0] COUNT_RESET = 11'd1024;

    localparam logic [63:0] ALL_ONES = '1;

endpackage

[rtl/dpat_ram.sv]
// ----------------------------------------------------------------------------
// dpat_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module dpat_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/demand_paged_address_translator.sv]
// ----------------------------------------------------------------------------
// demand_paged_address_translator: page table with demand allocation
// Usage: requests come in on s_axis (tdata = command, virt_addr, phys_addr_in),
// results leave on m_axis (tdata = status, phys_addr_out, virt_addr_out).
// One request is worked at a time. Translate, map and unmap scan the owner
// memory one entry a cycle, up to the effective page count, then answer
// through S_CHECK and S_OUT; handing out a recycled page also goes through
// S_POP to read the recycle fifo. Inverse reads one owner entry and answers
// through S_INV, S_INV2 and S_OUT. The owner RAM has a single port.
// Each owner entry carries its page valid bit.
// The result waits in an output register and s_tready is low until it is
// taken, so a stalled receiver holds the block after one finished request.
// The next request is taken the cycle after the result leaves.
// Reset (aresetn, synchronous, active low) loads the register defaults and
// starts a clearing pass over all NUM_PAGES owner RAM entries. Writing
// page_count empties the pool and runs that pass again. s_tready stays low
// during the pass. Registers sit on an APB port: phys_base at 0x0,
// page_shift at 0x8, page_count at 0x10.
// ----------------------------------------------------------------------------
module demand_paged_address_translator #(
    parameter int unsigned NUM_PAGES = dpat_pkg::NUM_PAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] command, [65:2] virt_addr, [129:66] phys_addr_in
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [65:2] phys_addr_out, [129:66] virt_addr_out
    output logic [135:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int unsigned IW = $clog2(NUM_PAGES);
    localparam int unsigned CW = IW + 1;

    localparam logic [1:0] REG_IDX0 = dpat_pkg::REG_PHYS_BASE;
    localparam logic [1:0] REG_IDX1 = dpat_pkg::REG_PAGE_SHIFT;
    localparam logic [1:0] REG_IDX2 = dpat_pkg::REG_PAGE_COUNT;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_CHECK = 8'b00000100,
        S_POP   = 8'b00001000,
        S_INV   = 8'b00010000,
        S_INV2  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_CLR   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] base_reg;
    logic [5:0]  shift_reg;
    logic [10:0] count_reg;
    logic [CW-1:0] eff;

    logic [CW-1:0] fresh_reg, rcnt_reg, left_reg;
    logic [IW-1:0] rhead_reg;
    logic [IW-1:0] clr_reg;

    logic [1:0]  cmd_reg;
    logic [63:0] va_reg;
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] idx_reg;
    logic        pend_reg;  // scan read in flight for idx_reg
    logic        found_reg;

    logic [1:0]  ost_reg;
    logic [63:0] opa_reg, ova_reg;
    logic        ovalid_reg;

    // owner ram ({valid, owner}) and recycle fifo ram controls
    logic          own_we, fifo_we;
    logic [IW-1:0] own_addr, fifo_addr;
    logic [64:0]   own_wdata, own_rdata;
    logic [IW-1:0] fifo_wdata, fifo_rdata;

    // recycle fifo tail, wrapped at the fifo depth
    logic [CW-1:0] tail_sum;
    logic [IW-1:0] fifo_tail;
    assign tail_sum  = {1'b0, rhead_reg} + rcnt_reg;
    assign fifo_tail = (tail_sum >= CW'(NUM_PAGES)) ? IW'(tail_sum - CW'(NUM_PAGES))
                                                    : IW'(tail_sum);

    logic cfg_wr, cfg_count_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_count_wr = cfg_wr && (paddr[4:3] == REG_IDX2);
    assign pready = 1'b1;

    always_comb begin
        if (32'(count_reg) > NUM_PAGES) begin
            eff = CW'(NUM_PAGES);
        end else begin
            eff = CW'(count_reg);
        end
    end

    // register read
    always_comb begin
        case (paddr[4:3])
            REG_IDX0: prdata = base_reg;
            REG_IDX1: prdata = {58'd0, shift_reg};
            REG_IDX2: prdata = {53'd0, count_reg};
            default:  prdata = 64'd0;
        endcase
    end

    function automatic logic [63:0] paddr_of(logic [63:0] b, logic [5:0] s,
                                             logic [IW-1:0] i);
        return b + (64'(i) << s);
    endfunction

    // inverse decode
    logic [63:0] inv_off, inv_i;
    assign inv_off = s_axis_tdata[129:66] - base_reg;
    assign inv_i   = inv_off >> shift_reg;

    logic scan_done, owner_hit, alloc_fresh, can_take;
    assign scan_done = scan_reg >= eff;
    assign owner_hit = pend_reg && own_rdata[64] && (own_rdata[63:0] == va_reg);
    assign alloc_fresh = fresh_reg < eff;
    assign can_take = (left_reg != '0) && (alloc_fresh || rcnt_reg != '0);

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

    // memory port steering
    always_comb begin
        own_we    = 1'b0;
        own_addr  = scan_reg[IW-1:0];
        own_wdata = {1'b1, va_reg};
        fifo_we   = 1'b0;
        fifo_addr = rhead_reg;
        fifo_wdata = idx_reg;
        if (state_reg == S_CLR) begin
            own_we    = 1'b1;
            own_addr  = clr_reg;
            own_wdata = '0;
        end
        if (state_reg == S_IDLE) begin
            own_addr = inv_i[IW-1:0];
        end
        if (state_reg == S_CHECK && cmd_reg != dpat_pkg::CMD_UNMAP && !found_reg
            && alloc_fresh && can_take) begin
            own_we   = 1'b1;
            own_addr = fresh_reg[IW-1:0];
        end
        if (state_reg == S_POP) begin
            own_we   = 1'b1;
            own_addr = fifo_rdata;
        end
        if (state_reg == S_CHECK && cmd_reg == dpat_pkg::CMD_UNMAP && found_reg
            && rcnt_reg < CW'(NUM_PAGES)) begin
            own_we    = 1'b1;
            own_addr  = idx_reg;
            own_wdata = {1'b0, va_reg};
            fifo_we   = 1'b1;
            fifo_addr = fifo_tail;
        end
    end

    dpat_ram #(.WIDTH(65), .DEPTH(NUM_PAGES)) u_owner (
        .aclk(aclk), .we(own_we), .addr(own_addr), .wdata(own_wdata),
        .rdata(own_rdata)
    );

    dpat_ram #(.WIDTH(IW), .DEPTH(NUM_PAGES)) u_fifo (
        .aclk(aclk), .we(fifo_we), .addr(fifo_addr), .wdata(fifo_wdata),
        .rdata(fifo_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tdata[1:0] == dpat_pkg::CMD_INVERSE) begin
                        state_next = S_INV;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (owner_hit || (scan_done && !pend_reg)) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (cmd_reg != dpat_pkg::CMD_UNMAP && !found_reg && can_take
                    && !alloc_fresh) begin
                    state_next = S_POP;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_POP:   state_next = S_OUT;
            S_INV:   state_next = S_INV2;
            S_INV2:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            S_CLR: begin
                if (clr_reg == IW'(NUM_PAGES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // a new pool size restarts the clearing pass
        if (cfg_count_wr) begin
            state_next = S_CLR;
        end
    end

    logic [63:0] inv_p_reg;
    logic        inv_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            base_reg   <= '0;
            shift_reg  <= dpat_pkg::SHIFT_RESET;
            count_reg  <= dpat_pkg::COUNT_RESET;
            fresh_reg  <= '0;
            rcnt_reg   <= '0;
            rhead_reg  <= '0;
            left_reg   <= CW'(NUM_PAGES < 1024 ? NUM_PAGES : 1024);
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            // clearing pass address
            if (cfg_count_wr) begin
                clr_reg <= '0;
            end else if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            // configuration
            if (cfg_wr) begin
                case (paddr[4:3])
                    REG_IDX0: base_reg <= pwdata;
                    REG_IDX1: shift_reg <= pwdata[5:0];
                    REG_IDX2: begin
                        count_reg <= pwdata[10:0];
                        fresh_reg <= '0;
                        rcnt_reg  <= '0;
                        rhead_reg <= '0;
                        if (32'(pwdata[10:0]) > NUM_PAGES) begin
                            left_reg <= CW'(NUM_PAGES);
                        end else begin
                            left_reg <= CW'(pwdata[10:0]);
                        end
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        cmd_reg   <= s_axis_tdata[1:0];
                        va_reg    <= s_axis_tdata[65:2];
                        inv_p_reg <= s_axis_tdata[129:66];
                        scan_reg  <= '0;
                        pend_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        idx_reg   <= inv_i[IW-1:0];
                        inv_ok_reg <= (inv_i < 64'(eff));
                    end
                end
                S_SCAN: begin
                    if (owner_hit) begin
                        found_reg <= 1'b1;
                        pend_reg  <= 1'b0;
                    end else begin
                        pend_reg <= !scan_done;
                        idx_reg  <= scan_reg[IW-1:0];
                        if (!scan_done) begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    ost_reg <= dpat_pkg::ST_FAIL;
                    opa_reg <= dpat_pkg::ALL_ONES;
                    ova_reg <= '0;
                    if (cmd_reg == dpat_pkg::CMD_UNMAP) begin
                        if (found_reg && rcnt_reg < CW'(NUM_PAGES)) begin
                            rcnt_reg <= rcnt_reg + 1'b1;
                            left_reg <= left_reg + 1'b1;
                            ost_reg  <= dpat_pkg::ST_OK;
                            opa_reg  <= paddr_of(base_reg, shift_reg, idx_reg);
                        end
                    end else if (found_reg) begin
                        ost_reg <= (cmd_reg == dpat_pkg::CMD_TRANSLATE) ?
                                   dpat_pkg::ST_OK : dpat_pkg::ST_MAPPED;
                        opa_reg <= paddr_of(base_reg, shift_reg, idx_reg);
                    end else if (can_take && alloc_fresh) begin
                        fresh_reg <= fresh_reg + 1'b1;
                        left_reg  <= left_reg - 1'b1;
                        ost_reg <= (cmd_reg == dpat_pkg::CMD_TRANSLATE) ?
                                   dpat_pkg::ST_NEW : dpat_pkg::ST_OK;
                        opa_reg <= paddr_of(base_reg, shift_reg, fresh_reg[IW-1:0]);
                    end
                end
                S_POP: begin
                    if (rhead_reg == IW'(NUM_PAGES - 1)) begin
                        rhead_reg <= '0;
                    end else begin
                        rhead_reg <= rhead_reg + 1'b1;
                    end
                    rcnt_reg  <= rcnt_reg - 1'b1;
                    left_reg  <= left_reg - 1'b1;
                    ost_reg <= (cmd_reg == dpat_pkg::CMD_TRANSLATE) ?
                               dpat_pkg::ST_NEW : dpat_pkg::ST_OK;
                    opa_reg <= paddr_of(base_reg, shift_reg, fifo_rdata);
                end
                S_INV: begin
                    // owner read issued in idle lands now
                    inv_ok_reg <= inv_ok_reg && own_rdata[64]
                                  && (paddr_of(base_reg, shift_reg, idx_reg) == inv_p_reg);
                    ova_reg <= own_rdata[63:0];
                end
                S_INV2: begin
                    opa_reg <= '0;
                    if (inv_ok_reg) begin
                        ost_reg <= dpat_pkg::ST_OK;
                    end else begin
                        ost_reg <= dpat_pkg::ST_FAIL;
                        ova_reg <= dpat_pkg::ALL_ONES;
                    end
                end
                S_OUT: ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, ova_reg, opa_reg, ost_reg};

    // a new request is never taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg |-> !s_axis_tready) else $error("request taken over result");
    // free pages never exceed the pool
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= CW'(NUM_PAGES)) else $error("pages_left overflow");
    // recycle count bounded
    a_rcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= CW'(NUM_PAGES)) else $error("recycle count overflow");

endmodule

[tb/demand_paged_address_translator_tb.sv]
// ----------------------------------------------------------------------------
// demand_paged_address_translator_tb: self-checking bench for the translator
// Streams translate, map, unmap and inverse requests with random gaps on both
// sides, predicts each result from a behavioral page pool kept in the bench
// and compares it field by field. Registers are rewritten between phases,
// while the block is idle, to walk through pool sizes, shifts and bases.
// ----------------------------------------------------------------------------
module demand_paged_address_translator_tb;

    localparam int unsigned NPG = dpat_pkg::NUM_PAGES_DEF;

    // last field in the lowest bits
    typedef struct packed {
        logic [63:0] paddr_in;
        logic [63:0] vaddr;
        logic [1:0]  cmd;
    } xlat_req_t;

    typedef struct packed {
        logic [63:0] vaddr_out;
        logic [63:0] paddr_out;
        logic [1:0]  status;
    } xlat_rsp_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [1:0] command, [65:2] virt_addr, [129:66] phys_addr_in
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [1:0] status, [65:2] phys_addr_out, [129:66] virt_addr_out
    logic [135:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    demand_paged_address_translator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // shadow of the registers and the page pool
    logic [63:0] cfg_base;
    logic [5:0]  cfg_shift;
    logic [10:0] cfg_count;
    logic [63:0] pool_owner[NPG];
    bit          pool_valid[NPG];
    logic [9:0]  recycle_q[NPG];
    int unsigned fresh_idx;
    int unsigned recycle_head;
    int unsigned recycle_cnt;
    int unsigned free_pages;

    xlat_req_t   req_q[$];
    xlat_rsp_t   expected_rsp_q[$];
    int unsigned n_errors = 0;
    bit          calm = 1'b0;

    function automatic int unsigned live_pages();
        return (cfg_count > NPG) ? NPG : int'(cfg_count);
    endfunction

    function automatic logic [63:0] page_address(int unsigned idx);
        return cfg_base + (64'(idx) << cfg_shift);
    endfunction

    function automatic void empty_pool();
        for (int i = 0; i < NPG; i++) pool_valid[i] = 1'b0;
        fresh_idx    = 0;
        recycle_head = 0;
        recycle_cnt  = 0;
        free_pages   = live_pages();
    endfunction

    function automatic int find_page(logic [63:0] v);
        for (int i = 0; i < live_pages(); i++)
            if (pool_valid[i] && pool_owner[i] == v) return i;
        return -1;
    endfunction

    function automatic int grab_page(logic [63:0] v);
        int idx;
        if (free_pages == 0) return -1;
        if (fresh_idx < live_pages()) begin
            idx = fresh_idx;
            fresh_idx++;
        end else if (recycle_cnt > 0) begin
            idx = recycle_q[recycle_head];
            recycle_head = (recycle_head + 1) % NPG;
            recycle_cnt--;
        end else begin
            return -1;
        end
        pool_valid[idx] = 1'b1;
        pool_owner[idx] = v;
        free_pages--;
        return idx;
    endfunction

    // expected response of one accepted request; updates the pool
    function automatic xlat_rsp_t translate_request(xlat_req_t r);
        xlat_rsp_t   o;
        int          idx;
        logic [63:0] pidx;
        o = '{status: dpat_pkg::ST_FAIL, paddr_out: '0, vaddr_out: '0};
        case (r.cmd)
            dpat_pkg::CMD_TRANSLATE, dpat_pkg::CMD_MAP: begin
                idx = find_page(r.vaddr);
                if (idx >= 0) begin
                    o.status    = (r.cmd == dpat_pkg::CMD_TRANSLATE) ?
                                  dpat_pkg::ST_OK : dpat_pkg::ST_MAPPED;
                    o.paddr_out = page_address(idx);
                end else begin
                    idx = grab_page(r.vaddr);
                    if (idx >= 0) begin
                        o.status    = (r.cmd == dpat_pkg::CMD_TRANSLATE) ?
                                      dpat_pkg::ST_NEW : dpat_pkg::ST_OK;
                        o.paddr_out = page_address(idx);
                    end else begin
                        o.paddr_out = dpat_pkg::ALL_ONES;
                    end
                end
            end
            dpat_pkg::CMD_UNMAP: begin
                idx = find_page(r.vaddr);
                if (idx >= 0 && recycle_cnt < NPG) begin
                    pool_valid[idx] = 1'b0;
                    recycle_q[(recycle_head + recycle_cnt) % NPG] = idx[9:0];
                    recycle_cnt++;
                    free_pages++;
                    o.status    = dpat_pkg::ST_OK;
                    o.paddr_out = page_address(idx);
                end else begin
                    o.paddr_out = dpat_pkg::ALL_ONES;
                end
            end
            default: begin
                pidx        = (r.paddr_in - cfg_base) >> cfg_shift;
                o.vaddr_out = dpat_pkg::ALL_ONES;
                if (pidx < 64'(live_pages()) && page_address(pidx[31:0]) == r.paddr_in
                        && pool_valid[pidx[9:0]]) begin
                    o.status    = dpat_pkg::ST_OK;
                    o.vaddr_out = pool_owner[pidx[9:0]];
                end
            end
        endcase
        return o;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // quiet stretches without any idling
    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
    end

    // request driver
    int unsigned src_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rsp_q.push_back(translate_request(xlat_req_t'(s_axis_tdata[129:0])));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_axis_tdata  <= {6'd0, req_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    src_gap       <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    int unsigned sink_gap;
    always @(posedge aclk) begin
        xlat_rsp_t got;
        xlat_rsp_t exp_rsp;
        int unsigned g;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = xlat_rsp_t'(m_axis_tdata[129:0]);
                if (expected_rsp_q.size() == 0) begin
                    $error("response with nothing expected: %h", got);
                    n_errors++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (got.status !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
                        n_errors++;
                    end
                    if (got.paddr_out !== exp_rsp.paddr_out) begin
                        $error("phys_addr_out: expected %h, actual %h",
                               exp_rsp.paddr_out, got.paddr_out);
                        n_errors++;
                    end
                    if (got.vaddr_out !== exp_rsp.vaddr_out) begin
                        $error("virt_addr_out: expected %h, actual %h",
                               exp_rsp.vaddr_out, got.vaddr_out);
                        n_errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && m_axis_tvalid) begin
                g = pick_gap();
                sink_gap      <= (g > 0) ? g - 1 : 0;
                m_axis_tready <= (g == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // register write over APB; only called while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dpat_pkg::REG_PHYS_BASE:  cfg_base = value;
            dpat_pkg::REG_PAGE_SHIFT: cfg_shift = value[5:0];
            dpat_pkg::REG_PAGE_COUNT: begin
                cfg_count = value[10:0];
                empty_pool();
            end
            default: ;
        endcase
    endtask

    // hold until every request went out and every response came back
    task automatic drain();
        while (req_q.size() > 0 || s_axis_tvalid || expected_rsp_q.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_req(logic [1:0] c, logic [63:0] v, logic [63:0] p);
        req_q.push_back('{cmd: c, vaddr: v, paddr_in: p});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random requests over a small set of virtual pages so hits, exhaustion
    // and recycling all happen
    task automatic random_phase(int unsigned n_req);
        logic [63:0] vpool[$];
        logic [63:0] v;
        logic [63:0] p;
        logic [1:0]  c;
        int unsigned roll;
        int unsigned pool_n;
        pool_n = live_pages() + 3;
        if (pool_n > 24) pool_n = 24;
        vpool.push_back('0);
        vpool.push_back(dpat_pkg::ALL_ONES);
        while (vpool.size() < pool_n) vpool.push_back(rand64());
        for (int k = 0; k < n_req; k++) begin
            roll = $urandom_range(0, 99);
            c = (roll < 35) ? dpat_pkg::CMD_TRANSLATE : (roll < 55) ? dpat_pkg::CMD_MAP :
                (roll < 85) ? dpat_pkg::CMD_UNMAP : dpat_pkg::CMD_INVERSE;
            v = ($urandom_range(0, 9) < 9) ? vpool[$urandom_range(0, vpool.size() - 1)]
                                           : rand64();
            roll = $urandom_range(0, 9);
            p = cfg_base + (64'($urandom_range(0, live_pages() + 1)) << cfg_shift);
            if (roll == 8) p = p + 64'd1;
            else if (roll == 9) p = rand64();
            queue_req(c, v, p);
        end
        drain();
    endtask

    // timeout
    initial begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_base      = '0;
        cfg_shift     = dpat_pkg::SHIFT_RESET;
        cfg_count     = dpat_pkg::COUNT_RESET;
        empty_pool();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, every command, hits, misses, misaligned
        queue_req(dpat_pkg::CMD_TRANSLATE, '0, '0);
        queue_req(dpat_pkg::CMD_TRANSLATE, dpat_pkg::ALL_ONES, '0);
        queue_req(dpat_pkg::CMD_TRANSLATE, dpat_pkg::ALL_ONES, '0);
        queue_req(dpat_pkg::CMD_MAP, '0, '0);
        queue_req(dpat_pkg::CMD_MAP, 64'h1234, '0);
        queue_req(dpat_pkg::CMD_INVERSE, '0, 64'h1000);
        queue_req(dpat_pkg::CMD_INVERSE, '0, 64'h1001);
        queue_req(dpat_pkg::CMD_INVERSE, '0, 64'h0040_0000);
        queue_req(dpat_pkg::CMD_INVERSE, '0, dpat_pkg::ALL_ONES);
        queue_req(dpat_pkg::CMD_UNMAP, 64'h5555, '0);
        queue_req(dpat_pkg::CMD_UNMAP, '0, '0);
        queue_req(dpat_pkg::CMD_INVERSE, '0, 64'h0);
        drain();

        // directed: tiny pool, exhaustion and reuse of a freed page
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd2);
        queue_req(dpat_pkg::CMD_TRANSLATE, 64'hA, '0);
        queue_req(dpat_pkg::CMD_MAP, 64'hB, '0);
        queue_req(dpat_pkg::CMD_TRANSLATE, 64'hC, '0);
        queue_req(dpat_pkg::CMD_MAP, 64'hD, '0);
        queue_req(dpat_pkg::CMD_UNMAP, 64'hA, '0);
        queue_req(dpat_pkg::CMD_TRANSLATE, 64'hC, '0);
        queue_req(dpat_pkg::CMD_INVERSE, '0, '0);
        drain();

        // directed: empty pool
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd0);
        queue_req(dpat_pkg::CMD_TRANSLATE, 64'h7, '0);
        queue_req(dpat_pkg::CMD_MAP, 64'h7, '0);
        queue_req(dpat_pkg::CMD_INVERSE, '0, '0);
        drain();

        // random phases over a range of settings
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd4);
        random_phase(60);
        write_reg(dpat_pkg::REG_PHYS_BASE, dpat_pkg::ALL_ONES);
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'd0);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd1);
        random_phase(30);
        write_reg(dpat_pkg::REG_PHYS_BASE, rand64());
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'd40);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd8);
        random_phase(80);
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'($urandom_range(0, 40)));
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd16);
        random_phase(80);
        write_reg(dpat_pkg::REG_PHYS_BASE, 64'hFFFF_FFFF_FFFF_F000);
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'd12);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd3);
        random_phase(60);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd0);
        random_phase(10);
        write_reg(dpat_pkg::REG_PHYS_BASE, rand64());
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'($urandom_range(0, 40)));
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd12);
        random_phase(80);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd6);
        random_phase(80);
        // oversized count saturates to the full pool
        write_reg(dpat_pkg::REG_PHYS_BASE, '0);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd2047);
        random_phase(15);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd1024);
        random_phase(15);
        write_reg(dpat_pkg::REG_PAGE_SHIFT, 64'd1);
        write_reg(dpat_pkg::REG_PAGE_COUNT, 64'd5);
        random_phase(50);

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[demand_paged_address_translator.f]
rtl/dpat_pkg.sv
rtl/dpat_ram.sv
rtl/demand_paged_address_translator.sv
tb/demand_paged_address_translator_tb.sv
